>>> hdl/cordic_sincos_atan2_engine_defines.svh
// ----------------------------------------------------------------------------
// CORDIC engine assertion macros
// Shared concurrent assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef CORDIC_SINCOS_ATAN2_ENGINE_DEFINES_SVH
`define CORDIC_SINCOS_ATAN2_ENGINE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CSE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/cse_pkg.sv
// ----------------------------------------------------------------------------
// CORDIC engine package
// Widths, command codes, stage types and the arctangent table.
// ----------------------------------------------------------------------------
package cse_pkg;

  // Iteration count and kept output precision.
  localparam int ITERATIONS = 24;
  localparam int DATA_WIDTH = 32;

  // Word and datapath widths. The x/y datapath holds the vectoring growth
  // of a normalized vector (below 2.4 times 2^31) with its sign.
  localparam int WORD_W = 32;
  localparam int DP_W   = 35;
  localparam int Z_W    = WORD_W + 1;

  // Pipeline layout: one stage for magnitudes, one per normalization step,
  // one for the half-turn fold, then one per iteration.
  localparam int NORM_STEPS = 5;
  localparam int ITER_BASE  = NORM_STEPS + 2;
  localparam int PIPE_DEPTH = ITER_BASE + ITERATIONS;

  // Command codes.
  localparam logic CMD_ROTATE = 1'b0;
  localparam logic CMD_VECTOR = 1'b1;

  // CORDIC gain 0.6072529350 in q1.31 and angle constants.
  localparam logic signed [DP_W-1:0] GAIN_Q31  = DP_W'(1304065748);
  localparam logic [WORD_W-1:0]      HALF_TURN = 32'h8000_0000;
  localparam logic [WORD_W-1:0]      KEEP_MASK =
    {WORD_W{1'b1}} << (WORD_W - DATA_WIDTH);

  // Word carried by every pipeline stage.
  typedef struct packed {
    logic                   cmd;
    logic                   flip;
    logic                   zero_vec;
    logic [WORD_W-1:0]      mag;
    logic signed [DP_W-1:0] x;
    logic signed [DP_W-1:0] y;
    logic [Z_W-1:0]         z;
  } cse_stage_t;

  // Finished result word.
  typedef struct packed {
    logic [WORD_W-1:0] cos_value;
    logic [WORD_W-1:0] sin_value;
    logic [WORD_W-1:0] angle_turns;
  } cse_result_t;

  // Arctangent of 2^-k in units of 2^-32 turn.
  function automatic logic [WORD_W-1:0] atan_turns(input logic [4:0] k);
    logic [WORD_W-1:0] r;
    unique case (k)
      5'd0:  r = 32'h2000_0000;
      5'd1:  r = 32'h12E4_051E;
      5'd2:  r = 32'h09FB_385B;
      5'd3:  r = 32'h0511_11D4;
      5'd4:  r = 32'h028B_0D43;
      5'd5:  r = 32'h0145_D7E1;
      5'd6:  r = 32'h00A2_F62E;
      5'd7:  r = 32'h0051_7C55;
      5'd8:  r = 32'h0028_BE53;
      5'd9:  r = 32'h0014_5F2F;
      5'd10: r = 32'h000A_2F98;
      5'd11: r = 32'h0005_17CC;
      5'd12: r = 32'h0002_8BE6;
      5'd13: r = 32'h0001_45F3;
      5'd14: r = 32'h0000_A2FA;
      5'd15: r = 32'h0000_517D;
      5'd16: r = 32'h0000_28BE;
      5'd17: r = 32'h0000_145F;
      5'd18: r = 32'h0000_0A30;
      5'd19: r = 32'h0000_0518;
      5'd20: r = 32'h0000_028C;
      5'd21: r = 32'h0000_0146;
      5'd22: r = 32'h0000_00A3;
      5'd23: r = 32'h0000_0051;
      5'd24: r = 32'h0000_0029;
      5'd25: r = 32'h0000_0014;
      5'd26: r = 32'h0000_000A;
      5'd27: r = 32'h0000_0005;
      5'd28: r = 32'h0000_0003;
      5'd29: r = 32'h0000_0001;
      5'd30: r = 32'h0000_0001;
      default: r = 32'h0000_0000;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/cse_stream_if.sv
// ----------------------------------------------------------------------------
// CORDIC engine stream interfaces
// Valid/ready channels for the request word and the result word.
// ----------------------------------------------------------------------------

// Request word: command and operands.
interface cse_req_if;
  import cse_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     command;
  logic [WORD_W-1:0]        angle_bam;
  logic signed [WORD_W-1:0] x_value;
  logic signed [WORD_W-1:0] y_value;

  modport source (output valid, command, angle_bam, x_value, y_value,
                  input ready);
  modport sink   (input valid, command, angle_bam, x_value, y_value,
                  output ready);
endinterface

// Result word: cosine, sine and angle.
interface cse_rsp_if;
  import cse_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] cos_value;
  logic signed [WORD_W-1:0] sin_value;
  logic [WORD_W-1:0]        angle_turns;

  modport source (output valid, cos_value, sin_value, angle_turns,
                  input ready);
  modport sink   (input valid, cos_value, sin_value, angle_turns,
                  output ready);
endinterface

>>> hdl/cordic_sincos_atan2_engine.sv
// ----------------------------------------------------------------------------
// CORDIC sine/cosine and atan2 engine
// Fully unrolled CORDIC pipeline: rotation mode gives cosine and sine of a
// binary angle, vectoring mode gives atan2 of a vector as a turn fraction.
// ----------------------------------------------------------------------------
//
//   channel  | role   | handshake     | word
//   ---------+--------+---------------+--------------------------------------
//   request  | sink   | valid / ready | command, angle_bam, x_value, y_value
//   result   | source | valid / ready | cos_value, sin_value, angle_turns
//
// One word enters per cycle while the skid register is free, and one result
// leaves per cycle while result.ready is high. Stages: a magnitude stage,
// five normalization steps, a half-turn fold, one per CORDIC iteration and
// the output register. Reset (rst, synchronous) clears only valid bits.
// When the result is stalled, one further word is caught in a skid register;
// while it is occupied the whole pipeline holds and request.ready is low.
// ----------------------------------------------------------------------------
`include "cordic_sincos_atan2_engine_defines.svh"

module cordic_sincos_atan2_engine (
  input logic       clk,
  input logic       rst,
  cse_req_if.sink   request,
  cse_rsp_if.source result
);
  import cse_pkg::*;

  cse_stage_t              pipe      [PIPE_DEPTH];
  cse_stage_t              pipe_next [PIPE_DEPTH];
  logic [PIPE_DEPTH-1:0]   pipe_v;
  logic                    en;
  logic                    s_valid;
  cse_result_t             fin;
  cse_result_t             out_q;
  cse_result_t             skid_q;
  logic                    out_v;
  logic                    skid_v;

  // The pipeline moves as one while the skid register is free.
  assign en            = !skid_v;
  assign s_valid       = pipe_v[PIPE_DEPTH-1] && en;
  assign request.ready = en;

  // Entry stage: quadrant fold for rotation, magnitudes for vectoring.
  logic [WORD_W-1:0] abs_x;
  logic [WORD_W-1:0] abs_y;
  logic              rot_flip;
  logic [WORD_W-1:0] rot_angle;
  cse_stage_t        entry;

  always_comb begin
    abs_x     = request.x_value[WORD_W-1] ? (WORD_W'(0) - request.x_value)
                                          : request.x_value;
    abs_y     = request.y_value[WORD_W-1] ? (WORD_W'(0) - request.y_value)
                                          : request.y_value;
    rot_flip  = (request.angle_bam[WORD_W-1] != request.angle_bam[WORD_W-2]);
    rot_angle = rot_flip ? (request.angle_bam ^ HALF_TURN) : request.angle_bam;
    entry     = '0;
    entry.cmd = request.command;
    if (request.command == CMD_ROTATE) begin
      entry.flip = rot_flip;
      entry.x    = GAIN_Q31;
      entry.y    = '0;
      entry.z    = Z_W'($signed(rot_angle));
    end else begin
      entry.mag      = abs_x | abs_y;
      entry.zero_vec = ((abs_x | abs_y) == '0);
      entry.x        = DP_W'(request.x_value);
      entry.y        = DP_W'(request.y_value);
    end
  end

  assign pipe_next[0] = entry;

  // Normalization: shift both components left by 16, 8, 4, 2 and 1 where the
  // shifted larger magnitude stays below 2^31. The OR of both magnitudes has
  // the same leading zeros as their maximum.
  for (genvar n = 0; n < NORM_STEPS; n++) begin : g_norm
    localparam int K = 1 << (NORM_STEPS - 1 - n);
    cse_stage_t cur;
    cse_stage_t nxt;

    always_comb begin
      cur = pipe[n];
      nxt = cur;
      if (cur.cmd == CMD_VECTOR && cur.mag[WORD_W-1:WORD_W-1-K] == '0) begin
        nxt.mag = cur.mag << K;
        nxt.x   = cur.x << K;
        nxt.y   = cur.y << K;
      end
    end

    assign pipe_next[n+1] = nxt;
  end

  // Half-turn fold: a vector in the left half plane is turned by half a
  // turn and the angle accumulator starts at half a turn.
  cse_stage_t fold_cur;
  cse_stage_t fold_nxt;

  always_comb begin
    fold_cur = pipe[NORM_STEPS];
    fold_nxt = fold_cur;
    if (fold_cur.cmd == CMD_VECTOR && fold_cur.x[DP_W-1]) begin
      fold_nxt.x = DP_W'(0) - fold_cur.x;
      fold_nxt.y = DP_W'(0) - fold_cur.y;
      fold_nxt.z = Z_W'(HALF_TURN);
    end
  end

  assign pipe_next[NORM_STEPS+1] = fold_nxt;

  // CORDIC iterations, one shift-add step per stage.
  for (genvar g = 0; g < ITERATIONS; g++) begin : g_iter
    localparam int IDX = ITER_BASE + g;
    cse_stage_t             cur;
    cse_stage_t             nxt;
    logic signed [DP_W-1:0] xs;
    logic signed [DP_W-1:0] ys;
    logic signed [DP_W-1:0] dx;
    logic signed [DP_W-1:0] dy;
    logic [Z_W-1:0]         at;
    logic                   plus;

    always_comb begin
      cur = pipe[IDX-1];
      nxt = cur;
      xs  = cur.x;
      ys  = cur.y;
      dx  = ys >>> g;
      dy  = xs >>> g;
      at  = Z_W'(atan_turns(5'(g)));
      // Turn counterclockwise when the angle is left to go (rotation) or
      // when the vector lies on or below the axis (vectoring).
      if (cur.cmd == CMD_VECTOR) begin
        plus = ys[DP_W-1] || (ys == '0);
      end else begin
        plus = !cur.z[Z_W-1];
      end
      if (plus) begin
        nxt.x = xs - dx;
        nxt.y = ys + dy;
        nxt.z = cur.z - at;
      end else begin
        nxt.x = xs + dx;
        nxt.y = ys - dy;
        nxt.z = cur.z + at;
      end
    end

    assign pipe_next[IDX] = nxt;
  end

  // Pipeline registers; valid bits travel with the words.
  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_v <= '0;
    end else if (en) begin
      pipe_v <= {pipe_v[PIPE_DEPTH-2:0], request.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < PIPE_DEPTH; i++) begin
        pipe[i] <= pipe_next[i];
      end
    end
  end

  // Clamp to the signed 32-bit range.
  function automatic logic [WORD_W-1:0] sat_q31(input logic signed [DP_W-1:0] v);
    logic [WORD_W-1:0] r;
    if (!v[DP_W-1] && (|v[DP_W-2:WORD_W-1])) begin
      r = {1'b0, {(WORD_W-1){1'b1}}};
    end else if (v[DP_W-1] && !(&v[DP_W-2:WORD_W-1])) begin
      r = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      r = v[WORD_W-1:0];
    end
    return r;
  endfunction

  // Finish: undo the quadrant fold, saturate and keep the top bits.
  cse_stage_t             last;
  logic signed [DP_W-1:0] xr;
  logic signed [DP_W-1:0] yr;

  always_comb begin
    last = pipe[PIPE_DEPTH-1];
    xr   = last.flip ? (DP_W'(0) - last.x) : last.x;
    yr   = last.flip ? (DP_W'(0) - last.y) : last.y;
    fin  = '0;
    if (last.cmd == CMD_ROTATE) begin
      fin.cos_value = sat_q31(xr) & KEEP_MASK;
      fin.sin_value = sat_q31(yr) & KEEP_MASK;
    end else if (!last.zero_vec) begin
      fin.angle_turns = last.z[WORD_W-1:0] & KEEP_MASK;
    end
  end

  // Output register with a one-word skid register behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (result.ready) begin
        out_v  <= 1'b1;
        skid_v <= 1'b0;
      end
    end else if (s_valid) begin
      if (out_v && !result.ready) begin
        skid_v <= 1'b1;
      end else begin
        out_v <= 1'b1;
      end
    end else if (result.ready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (result.ready) begin
        out_q <= skid_q;
      end
    end else if (s_valid) begin
      if (out_v && !result.ready) begin
        skid_q <= fin;
      end else begin
        out_q <= fin;
      end
    end
  end

  assign result.valid       = out_v;
  assign result.cos_value   = out_q.cos_value;
  assign result.sin_value   = out_q.sin_value;
  assign result.angle_turns = out_q.angle_turns;

  // The skid register is only occupied behind a full output register.
  `CSE_ASSERT_SAME(a_skid_behind_out, clk, rst, skid_v, out_v, "skid word without output word")

  // The skid register fills only when the output word was stalled.
  `CSE_ASSERT_SAME(a_skid_fill_on_stall, clk, rst, $rose(skid_v), $past(out_v && !result.ready), "skid filled without a stall")

  // A result carries either a cosine/sine pair or an angle, never both.
  `CSE_ASSERT_SAME(a_one_mode_result, clk, rst, result.valid, (result.angle_turns == '0) || ((result.cos_value == '0) && (result.sin_value == '0)), "result mixes both modes")

endmodule

>>> verif/cordic_sincos_atan2_engine_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CORDIC sine/cosine and atan2 engine testbench
// Drives request words through the valid/ready channel with random gaps and
// result back-pressure, including one long hold that fills the pipeline.
// Every accepted request is predicted bit for bit by a local CORDIC model,
// and every result word is checked in order against those predictions.
// ----------------------------------------------------------------------------

// Holds the expected result words in order and compares arriving results.
class cordic_result_scoreboard;
  cse_pkg::cse_result_t expected_words[$];
  int unsigned          mismatches;
  logic [31:0]          atan_step [32];
  logic [31:0]          keep_mask;
  longint               gain_q31;

  function new();
    mismatches = 0;
    gain_q31   = 64'sd1304065748;
    keep_mask  = 32'hFFFF_FFFF << (32 - cse_pkg::DATA_WIDTH);
    atan_step  = '{
      32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
      32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F62E, 32'h0051_7C55,
      32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
      32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
      32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
      32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051,
      32'h0000_0029, 32'h0000_0014, 32'h0000_000A, 32'h0000_0005,
      32'h0000_0003, 32'h0000_0001, 32'h0000_0001, 32'h0000_0000};
  endfunction

  // Prints one line for a mismatch and counts it.
  task report(input string what);
    mismatches++;
    $display("%0t: mismatch: %s", $realtime, what);
  endtask

  // Clamps a datapath value to the signed 32-bit range.
  function logic [31:0] saturate_q31(input longint v);
    if (v > 64'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // Rotation mode: cosine and sine of a binary angle.
  function void rotate_to_sincos(input logic [31:0] angle,
                                 output logic [31:0] cos_q31,
                                 output logic [31:0] sin_q31);
    logic [31:0] a;
    bit          flip;
    longint      x, y, z, dx, dy;
    int          s;
    a    = angle;
    flip = 1'b0;
    // Second and third quarter turns are folded by half a turn.
    if (a[31] != a[30]) begin
      a    = a - cse_pkg::HALF_TURN;
      flip = 1'b1;
    end
    z = longint'($signed(a));
    x = gain_q31;
    y = 0;
    for (int i = 0; i < cse_pkg::ITERATIONS; i++) begin
      s  = i % 32;
      dx = y >>> s;
      dy = x >>> s;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= longint'(atan_step[s]);
      end else begin
        x += dx;
        y -= dy;
        z += longint'(atan_step[s]);
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    cos_q31 = saturate_q31(x) & keep_mask;
    sin_q31 = saturate_q31(y) & keep_mask;
  endfunction

  // Vectoring mode: atan2(y, x) as a fraction of a full turn.
  function logic [31:0] vector_to_turns(input logic signed [31:0] xv,
                                        input logic signed [31:0] yv);
    longint      x, y, ax, ay, m, dx, dy;
    logic [31:0] z;
    int          sh, k;
    x  = xv;
    y  = yv;
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    m  = (ax > ay) ? ax : ay;
    if (m == 0) begin
      return 32'h0;
    end
    // Normalize so the larger magnitude is at least 2^30.
    sh = 0;
    while ((m << sh) < 64'sd1073741824) begin
      sh++;
    end
    x = x <<< sh;
    y = y <<< sh;
    z = 32'h0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = cse_pkg::HALF_TURN;
    end
    for (int i = 0; i < cse_pkg::ITERATIONS; i++) begin
      k  = i % 32;
      dx = y >>> k;
      dy = x >>> k;
      if (y > 0) begin
        x += dx;
        y -= dy;
        z += atan_step[k];
      end else begin
        x -= dx;
        y += dy;
        z -= atan_step[k];
      end
    end
    return z & keep_mask;
  endfunction

  // Notes an accepted request word and queues its expected result.
  function void note_request(input logic cmd, input logic [31:0] angle,
                             input logic signed [31:0] xv,
                             input logic signed [31:0] yv);
    cse_pkg::cse_result_t r;
    r = '0;
    if (cmd == cse_pkg::CMD_ROTATE) begin
      rotate_to_sincos(angle, r.cos_value, r.sin_value);
    end else begin
      r.angle_turns = vector_to_turns(xv, yv);
    end
    expected_words.push_back(r);
  endfunction

  // Checks an accepted result word against the oldest expectation.
  task check_result(input logic [31:0] cos_v, input logic [31:0] sin_v,
                    input logic [31:0] turns_v);
    cse_pkg::cse_result_t e;
    if (expected_words.size() == 0) begin
      report($sformatf("result word %h %h %h with no request pending",
                       cos_v, sin_v, turns_v));
    end else begin
      e = expected_words.pop_front();
      if (cos_v !== e.cos_value) begin
        report($sformatf("cos_value %h, expected %h", cos_v, e.cos_value));
      end
      if (sin_v !== e.sin_value) begin
        report($sformatf("sin_value %h, expected %h", sin_v, e.sin_value));
      end
      if (turns_v !== e.angle_turns) begin
        report($sformatf("angle_turns %h, expected %h", turns_v, e.angle_turns));
      end
    end
  endtask

  function int pending();
    return expected_words.size();
  endfunction
endclass

module cordic_sincos_atan2_engine_tb;
  import cse_pkg::*;

  localparam int STALL_LIMIT   = 3000;
  localparam int HOLD_CYCLES   = 300;
  localparam int TAIL_CYCLES   = 40;
  localparam int RANDOM_WORDS  = 1500;
  localparam int PRESSURE_WORDS = 80;

  logic clk;
  logic rst;

  cse_req_if req_ch ();
  cse_rsp_if rsp_ch ();

  cordic_result_scoreboard results_sb;

  // Pacing controls for the request and result processes, and the monitor's idle count.
  bit sender_idles;
  bit receiver_idles;
  bit hold_pending;
  int quiet_cycles;

  cordic_sincos_atan2_engine i_dut (
    .clk     (clk),
    .rst     (rst),
    .request (req_ch),
    .result  (rsp_ch)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Monitor both channels and watch for a hung pipeline.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        results_sb.note_request(req_ch.command, req_ch.angle_bam,
                                req_ch.x_value, req_ch.y_value);
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        results_sb.check_result(rsp_ch.cos_value, rsp_ch.sin_value,
                                rsp_ch.angle_turns);
      end
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("cordic_sincos_atan2_engine_tb NOT OK");
        $finish;
      end
    end
  end

  // Offers one request word after an optional gap and waits until it is taken.
  task send_word(input logic cmd, input logic [31:0] angle,
                 input logic [31:0] xv, input logic [31:0] yv);
    int gap;
    gap = sender_idles ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.command   <= cmd;
    req_ch.angle_bam <= angle;
    req_ch.x_value   <= xv;
    req_ch.y_value   <= yv;
    do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
  endtask

  // Operand with a wide spread of magnitudes so normalization is exercised.
  function automatic logic [31:0] draw_operand();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 5))
      0, 1:    return v;
      2, 3:    return $signed(v) >>> $urandom_range(1, 31);
      4:       return $signed(v) >>> 28;
      default: begin
        case ($urandom_range(0, 4))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return 32'h0000_0000;
          3:       return 32'hFFFF_FFFF;
          default: return 32'h0000_0001;
        endcase
      end
    endcase
  endfunction

  // Angle that is either uniform or near a quarter-turn boundary.
  function automatic logic [31:0] draw_angle();
    logic [31:0] base;
    if ($urandom_range(0, 3) != 0) begin
      return $urandom;
    end
    base = 32'($urandom_range(0, 3)) << 30;
    return base + 32'($urandom_range(0, 8)) - 32'd4;
  endfunction

  // Result side: random stalls per word, plus one long hold on request.
  initial begin
    int stall;
    bit held;
    held         = 1'b0;
    rsp_ch.ready = 1'b0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      if (hold_pending && !held) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held = 1'b1;
      end else begin
        stall = receiver_idles ? $urandom_range(0, 19) : 0;
        if (stall > 0) begin
          rsp_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
    end
  end

  // Request side: directed words, a pressure burst, then random words.
  initial begin
    results_sb       = new();
    sender_idles     = 1'b1;
    receiver_idles   = 1'b1;
    hold_pending     = 1'b0;
    rst              = 1'b1;
    req_ch.valid     = 1'b0;
    req_ch.command   = CMD_ROTATE;
    req_ch.angle_bam = '0;
    req_ch.x_value   = '0;
    req_ch.y_value   = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Rotation: quadrant edges, full-scale saturation and fold boundaries.
    // Unused vector fields of the first two words carry junk that must be ignored.
    send_word(CMD_ROTATE, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    send_word(CMD_ROTATE, 32'h4000_0000, 32'hFFFF_FFFF, 32'h1234_5678);
    send_word(CMD_ROTATE, 32'h8000_0000, '0, '0);
    send_word(CMD_ROTATE, 32'hC000_0000, '0, '0);
    send_word(CMD_ROTATE, 32'hFFFF_FFFF, '0, '0);
    send_word(CMD_ROTATE, 32'h3FFF_FFFF, '0, '0);
    send_word(CMD_ROTATE, 32'h7FFF_FFFF, '0, '0);
    send_word(CMD_ROTATE, 32'h8000_0001, '0, '0);
    send_word(CMD_ROTATE, 32'hBFFF_FFFF, '0, '0);
    send_word(CMD_ROTATE, 32'h2000_0000, '0, '0);
    // Vectoring: zero vector, axes, left half plane and extreme magnitudes.
    // The unused angle field of the first two words carries junk that must be ignored.
    send_word(CMD_VECTOR, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
    send_word(CMD_VECTOR, 32'hA5A5_A5A5, 32'h0000_0001, 32'h0000_0000);
    send_word(CMD_VECTOR, '0, 32'h0000_0000, 32'h0000_0001);
    send_word(CMD_VECTOR, '0, 32'hFFFF_FFFF, 32'h0000_0000);
    send_word(CMD_VECTOR, '0, 32'h0000_0000, 32'hFFFF_FFFF);
    send_word(CMD_VECTOR, '0, 32'h8000_0000, 32'h8000_0000);
    send_word(CMD_VECTOR, '0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_word(CMD_VECTOR, '0, 32'h8000_0000, 32'h0000_0000);
    send_word(CMD_VECTOR, '0, 32'h0000_0000, 32'h8000_0000);
    send_word(CMD_VECTOR, '0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_word(CMD_VECTOR, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(CMD_VECTOR, '0, 32'h8000_0000, 32'h0000_0001);
    send_word(CMD_VECTOR, '0, 32'hFFFF_FFFF, 32'h0000_0001);

    // Back-to-back words against a long result hold fill the pipeline.
    sender_idles = 1'b0;
    hold_pending = 1'b1;
    for (int n = 0; n < PRESSURE_WORDS; n++) begin
      send_word(logic'($urandom_range(0, 1)), draw_angle(), draw_operand(),
                draw_operand());
    end

    // Random words in blocks that change which side idles.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 150 == 0) begin
        case ((n / 150) % 4)
          0: begin sender_idles = 1'b0; receiver_idles = 1'b0; end
          1: begin sender_idles = 1'b1; receiver_idles = 1'b1; end
          2: begin sender_idles = 1'b1; receiver_idles = 1'b0; end
          default: begin sender_idles = 1'b0; receiver_idles = 1'b1; end
        endcase
      end
      send_word(logic'($urandom_range(0, 1)), draw_angle(), draw_operand(),
                draw_operand());
    end
    req_ch.valid <= 1'b0;

    // Drain, then watch a little longer for stray result words.
    while (results_sb.pending() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (results_sb.mismatches == 0 && results_sb.pending() == 0) begin
      $display("cordic_sincos_atan2_engine_tb OK");
    end else begin
      $display("cordic_sincos_atan2_engine_tb NOT OK");
    end
    $finish;
  end

endmodule
